@@ rtl/pbrf_pkg.sv @@
package pbrf_pkg;

    localparam int LEN_W  = 7;
    localparam int DATA_W = 8;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NO_DATA  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        KIND_PUT,
        KIND_PUT_FIRST,
        KIND_GET,
        KIND_GET_FAIL,
        KIND_CLEAR,
        KIND_NOP
    } kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_GET
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic [LEN_W-1:0]  packet_len;
        logic              first_byte;
        logic [DATA_W-1:0] data_in;
    } pbrf_in_t;

    typedef struct packed {
        status_t           status;
        logic              data_valid;
        logic [DATA_W-1:0] data_out;
        logic              last_of_run;
        logic [LEN_W-1:0]  free_count;
        logic [LEN_W-1:0]  fill_count;
    } pbrf_out_t;

    typedef struct packed {
        kind_t             kind;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } qent_t;

    typedef struct packed {
        logic  valid;
        qent_t entry;
    } qhead_t;

endpackage

@@ rtl/pbrf_ram.sv @@
module pbrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/pbrf_front.sv @@
module pbrf_front
    import pbrf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  pbrf_in_t cmd,
    output logic     busy,
    input  logic     pop,
    output qhead_t   head
);

    qent_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    qent_t       cls;

    // classify the incoming word
    always_comb
    begin
        cls.len  = cmd.packet_len;
        cls.data = cmd.data_in;
        case (cmd.op)
            OP_PUT:
            begin
                cls.kind = cmd.first_byte ? KIND_PUT_FIRST : KIND_PUT;
            end
            OP_GET:
            begin
                if (cmd.packet_len == '0)
                begin
                    cls.kind = KIND_NOP;
                end
                else if (cmd.packet_len > LEN_W'(DEPTH))
                begin
                    cls.kind = KIND_GET_FAIL;
                end
                else
                begin
                    cls.kind = KIND_GET;
                end
            end
            OP_CLEAR:
            begin
                cls.kind = KIND_CLEAR;
            end
            default:
            begin
                cls.kind = KIND_NOP;
            end
        endcase
    end

    assign busy        = count_reg[1];
    assign push        = start && !busy;
    assign wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    assign head.valid = count_reg != 2'd0;
    assign head.entry = entry_reg[rd_ptr_reg];

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");

endmodule

@@ rtl/pbrf_back.sv @@
module pbrf_back
    import pbrf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  qhead_t    head,
    output logic      pop,
    output logic      strobe,
    output pbrf_out_t result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  wp_next;
    logic [PTR_W-1:0]  rp_reg;
    logic [PTR_W-1:0]  rp_next;
    logic              lap_reg;
    logic              lap_next;
    logic              acc_reg;
    logic              acc_next;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  rem_next;
    logic [LEN_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  cnt_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    status_t           res_status_reg;
    status_t           res_status_next;
    logic              res_dv_reg;
    logic              res_dv_next;
    logic              res_last_reg;
    logic              res_last_next;

    logic [PTR_W-1:0]  wp_inc;
    logic [PTR_W-1:0]  rp_inc;
    logic [PTR_W-1:0]  free_diff;
    logic [PTR_W-1:0]  fill_diff;
    logic              ptr_eq;
    logic [CNT_W-1:0]  free_cnt;
    logic [CNT_W-1:0]  fill_cnt;
    logic [LEN_W-1:0]  free_len;
    logic [LEN_W-1:0]  fill_len;
    logic [LEN_W-1:0]  rem_eff;
    logic              acc_eff;
    logic              get_ok;
    logic              we;
    logic              re;
    logic [DATA_W-1:0] rdata;

    assign wp_inc    = wp_reg + 1'b1;
    assign rp_inc    = rp_reg + 1'b1;
    assign free_diff = rp_reg - wp_reg;
    assign fill_diff = wp_reg - rp_reg;
    assign ptr_eq    = wp_reg == rp_reg;
    assign free_cnt  = (ptr_eq && !lap_reg) ? CNT_W'(DEPTH) : {1'b0, free_diff};
    assign fill_cnt  = (ptr_eq && lap_reg) ? CNT_W'(DEPTH) : {1'b0, fill_diff};
    assign free_len  = LEN_W'(free_cnt);
    assign fill_len  = LEN_W'(fill_cnt);
    assign get_ok    = head.entry.len <= fill_len;

    pbrf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wp_reg),
        .wdata (head.entry.data),
        .re    (re),
        .raddr (rp_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid && head.entry.kind == KIND_GET && get_ok
                    && head.entry.len != LEN_W'(1))
                begin
                    state_next = BK_GET;
                end
            end
            BK_GET:
            begin
                if (cnt_reg == LEN_W'(1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop             = 1'b0;
        we              = 1'b0;
        re              = 1'b0;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        lap_next        = lap_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        rem_eff         = rem_reg;
        acc_eff         = acc_reg;
        res_valid_next  = 1'b0;
        res_status_next = ST_OK;
        res_dv_next     = 1'b0;
        res_last_next   = 1'b1;
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop            = 1'b1;
                    res_valid_next = 1'b1;
                    case (head.entry.kind)
                        KIND_PUT, KIND_PUT_FIRST:
                        begin
                            if (head.entry.kind == KIND_PUT_FIRST)
                            begin
                                rem_eff = head.entry.len;
                                acc_eff = free_len >= head.entry.len;
                            end
                            acc_next = acc_eff;
                            if (rem_eff == '0)
                            begin
                                rem_next        = '0;
                                res_status_next = (head.entry.kind == KIND_PUT_FIRST && acc_eff)
                                                  ? ST_OK : ST_NO_SPACE;
                            end
                            else
                            begin
                                rem_next = rem_eff - 1'b1;
                                if (acc_eff && free_cnt != '0)
                                begin
                                    we      = 1'b1;
                                    wp_next = wp_inc;
                                    if (wp_inc == '0)
                                    begin
                                        lap_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    res_status_next = ST_NO_SPACE;
                                end
                            end
                        end
                        KIND_GET:
                        begin
                            if (!get_ok)
                            begin
                                res_status_next = ST_NO_DATA;
                            end
                            else
                            begin
                                re            = 1'b1;
                                rp_next       = rp_inc;
                                res_dv_next   = 1'b1;
                                res_last_next = head.entry.len == LEN_W'(1);
                                cnt_next      = head.entry.len - 1'b1;
                                if (rp_inc == '0)
                                begin
                                    lap_next = 1'b0;
                                end
                            end
                        end
                        KIND_GET_FAIL:
                        begin
                            res_status_next = ST_NO_DATA;
                        end
                        KIND_CLEAR:
                        begin
                            wp_next  = '0;
                            rp_next  = '0;
                            lap_next = 1'b0;
                            acc_next = 1'b0;
                            rem_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_GET:
            begin
                re             = 1'b1;
                rp_next        = rp_inc;
                res_valid_next = 1'b1;
                res_dv_next    = 1'b1;
                res_last_next  = cnt_reg == LEN_W'(1);
                cnt_next       = cnt_reg - 1'b1;
                if (rp_inc == '0)
                begin
                    lap_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            lap_reg       <= 1'b0;
            acc_reg       <= 1'b0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            lap_reg       <= lap_next;
            acc_reg       <= acc_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_dv_reg     <= res_dv_next;
        res_last_reg   <= res_last_next;
    end

    assign strobe             = res_valid_reg;
    assign result.status      = res_status_reg;
    assign result.data_valid  = res_dv_reg;
    assign result.data_out    = res_dv_reg ? rdata : '0;
    assign result.last_of_run = res_last_reg;
    assign result.free_count  = LEN_W'(free_cnt);
    assign result.fill_count  = LEN_W'(fill_cnt);

    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, free_cnt} + {1'b0, fill_cnt}) == (CNT_W + 1)'(DEPTH))
        else $error("free and fill counts disagree");

    a_get_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_GET) |-> (cnt_reg != '0 && fill_len >= cnt_reg && !pop))
        else $error("get stream overruns stored bytes");

    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.data_valid) |-> (result.status == ST_OK))
        else $error("read byte with error status");

endmodule

@@ rtl/packet_byte_ring_fifo.sv @@
// With the back idle, a word is held in a command queue entry and then in the result registers
// before its first result is on the result port.
// Put, clear and no-op words: one result each, sustained one word per cycle.
// Get of n stored bytes: n results, one ring store read per cycle;
// the 2-entry command queue takes up to two more words while the get streams, then holds busy.
// Reset clears pointers, lap flag, open packet and queue; store contents stay undefined.
module packet_byte_ring_fifo
    import pbrf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  pbrf_in_t  cmd,
    output logic      busy,
    output logic      strobe,
    output pbrf_out_t result
);

    qhead_t head;
    logic   pop;

    pbrf_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .pop   (pop),
        .head  (head)
    );

    pbrf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

@@ tb/sv/packet_byte_ring_fifo_test.sv @@
`timescale 1ns / 1ps

module packet_byte_ring_fifo_test;
    import pbrf_pkg::*;

    localparam int RING         = 64;
    localparam int RANDOM_WORDS = 105;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        pbrf_in_t  word;
        logic      typed;
        pbrf_out_t want;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    pbrf_in_t  cmd = '0;
    logic      busy;
    logic      strobe;
    pbrf_out_t result;

    logic [DATA_W-1:0] ring_img [RING];
    logic [5:0]        wr_ptr;
    logic [5:0]        rd_ptr;
    logic              lap;
    logic              pkt_open;
    int                pkt_left;

    pbrf_out_t step_out [$];
    pbrf_out_t fifo_results_due [$];
    dir_row_t  dir_rows [$];
    pbrf_out_t want;

    int errors = 0;
    int checked = 0;
    int read_bytes = 0;
    int words_sent = 0;
    int cycles = 0;
    int quiet_left = 0;

    packet_byte_ring_fifo #(.DEPTH(RING)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, fifo_results_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int free_bytes();
        if (rd_ptr == wr_ptr && !lap)
            return RING;
        return (RING - int'(wr_ptr) + int'(rd_ptr)) & (RING - 1);
    endfunction

    function automatic int fill_bytes();
        if (rd_ptr == wr_ptr && lap)
            return RING;
        return (int'(wr_ptr) - int'(rd_ptr)) & (RING - 1);
    endfunction

    function automatic pbrf_in_t mk(op_t op, int len, bit first, int data);
        pbrf_in_t w;
        w.op         = op;
        w.packet_len = len[LEN_W-1:0];
        w.first_byte = first;
        w.data_in    = data[DATA_W-1:0];
        return w;
    endfunction

    function automatic pbrf_out_t brief(status_t st, int free_n, int fill_n);
        pbrf_out_t r;
        r.status      = st;
        r.data_valid  = 1'b0;
        r.data_out    = '0;
        r.last_of_run = 1'b1;
        r.free_count  = free_n[LEN_W-1:0];
        r.fill_count  = fill_n[LEN_W-1:0];
        return r;
    endfunction

    task automatic push_result(status_t st, bit valid, logic [DATA_W-1:0] b, bit last);
        pbrf_out_t r;
        int        free_n;
        int        fill_n;
        free_n        = free_bytes();
        fill_n        = fill_bytes();
        r.status      = st;
        r.data_valid  = valid;
        r.data_out    = b;
        r.last_of_run = last;
        r.free_count  = free_n[LEN_W-1:0];
        r.fill_count  = fill_n[LEN_W-1:0];
        step_out.push_back(r);
    endtask

    task automatic fifo_step(input pbrf_in_t w);
        int                n;
        status_t           st;
        logic [DATA_W-1:0] b;
        step_out.delete();
        n = int'(w.packet_len);
        case (w.op)
            OP_PUT:
            begin
                if (w.first_byte)
                begin
                    pkt_left = n;
                    pkt_open = (free_bytes() >= n);
                end
                if (pkt_left == 0)
                    st = (w.first_byte && pkt_open) ? ST_OK : ST_NO_SPACE;
                else
                begin
                    pkt_left--;
                    if (pkt_open && free_bytes() > 0)
                    begin
                        ring_img[wr_ptr] = w.data_in;
                        wr_ptr = wr_ptr + 1'b1;
                        if (wr_ptr == 0)
                            lap = 1'b1;
                        st = ST_OK;
                    end
                    else
                        st = ST_NO_SPACE;
                end
                push_result(st, 1'b0, '0, 1'b1);
            end
            OP_GET:
            begin
                if (n > fill_bytes())
                    push_result(ST_NO_DATA, 1'b0, '0, 1'b1);
                else if (n == 0)
                    push_result(ST_OK, 1'b0, '0, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                    begin
                        b = ring_img[rd_ptr];
                        rd_ptr = rd_ptr + 1'b1;
                        if (rd_ptr == 0)
                            lap = 1'b0;
                        push_result(ST_OK, 1'b1, b, i == n - 1);
                    end
            end
            OP_CLEAR:
            begin
                wr_ptr   = '0;
                rd_ptr   = '0;
                lap      = 1'b0;
                pkt_open = 1'b0;
                pkt_left = 0;
                push_result(ST_OK, 1'b0, '0, 1'b1);
            end
            default:
                push_result(ST_OK, 1'b0, '0, 1'b1);
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic send_word(input pbrf_in_t w, input bit typed, input pbrf_out_t typed_want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        fifo_step(w);
        if (typed)
            fifo_results_due.push_back(typed_want);
        else
            foreach (step_out[i])
                fifo_results_due.push_back(step_out[i]);
        words_sent++;
    endtask

    task automatic put_byte(input int len, input bit first);
        send_word(mk(OP_PUT, len, first, $urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic put_packet(input int len, input int count);
        put_byte(len, 1'b1);
        for (int k = 1; k < count; k++)
            put_byte($urandom_range(0, 127), 1'b0);
    endtask

    task automatic get_packet(input int len);
        send_word(mk(OP_GET, len, 1'($urandom_range(0, 1)), $urandom_range(0, 255)),
                  1'b0, '0);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 90)
            return $urandom_range(9, 24);
        if (r < 98)
            return $urandom_range(25, RING);
        return 0;
    endfunction

    function automatic int pick_get_len();
        int r;
        int f;
        r = $urandom_range(0, 99);
        f = fill_bytes();
        if (r < 60)
            return (f > 0) ? $urandom_range(1, f) : 1;
        if (r < 80)
            return $urandom_range(0, 8);
        if (r < 90)
            return (f < RING) ? $urandom_range(f + 1, RING) : RING;
        return $urandom_range(0, 127);
    endfunction

    task automatic add_row(input pbrf_in_t w, input bit typed, input pbrf_out_t row_want);
        dir_row_t row;
        row.word  = w;
        row.typed = typed;
        row.want  = row_want;
        dir_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (fifo_results_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, result);
            end
            else
            begin
                want = fifo_results_due.pop_front();
                checked++;
                if (result.data_valid === 1'b1)
                    read_bytes++;
                if (result.status !== want.status || result.data_valid !== want.data_valid ||
                    result.data_out !== want.data_out ||
                    result.last_of_run !== want.last_of_run ||
                    result.free_count !== want.free_count ||
                    result.fill_count !== want.fill_count)
                begin
                    errors++;
                    $display("%0t: mismatch, expected status=%0d valid=%0d data=%02h last=%0d",
                             $time, want.status, want.data_valid, want.data_out,
                             want.last_of_run);
                    $display("    free=%0d fill=%0d, actual status=%0d valid=%0d data=%02h",
                             want.free_count, want.fill_count, result.status,
                             result.data_valid, result.data_out);
                    $display("    last=%0d free=%0d fill=%0d", result.last_of_run,
                             result.free_count, result.fill_count);
                end
            end
        end
    end

    initial
    begin
        int r;
        int len;
        int directed_words;
        wr_ptr   = '0;
        rd_ptr   = '0;
        lap      = 1'b0;
        pkt_open = 1'b0;
        pkt_left = 0;

        add_row(mk(OP_GET, 0, 1'b0, 8'h00), 1'b1, brief(ST_OK, RING, 0));
        add_row(mk(OP_GET, 1, 1'b1, 8'hFF), 1'b1, brief(ST_NO_DATA, RING, 0));
        add_row(mk(OP_GET, 127, 1'b0, 8'h00), 1'b1, brief(ST_NO_DATA, RING, 0));
        add_row(mk(OP_PUT, 127, 1'b1, 8'h00), 1'b1, brief(ST_NO_SPACE, RING, 0));
        add_row(mk(OP_PUT, 127, 1'b0, 8'hFF), 1'b1, brief(ST_NO_SPACE, RING, 0));
        add_row(mk(OP_CLEAR, 127, 1'b1, 8'hFF), 1'b1, brief(ST_OK, RING, 0));
        add_row(mk(OP_PUT, 0, 1'b0, 8'h3C), 1'b1, brief(ST_NO_SPACE, RING, 0));
        add_row(mk(OP_PUT, 0, 1'b1, 8'hC3), 1'b1, brief(ST_OK, RING, 0));
        add_row(mk(OP_NOP, 127, 1'b1, 8'hFF), 1'b1, brief(ST_OK, RING, 0));
        add_row(mk(OP_PUT, 3, 1'b1, 8'hA5), 1'b1, brief(ST_OK, RING - 1, 1));
        add_row(mk(OP_PUT, 0, 1'b0, 8'h00), 1'b0, '0);
        add_row(mk(OP_GET, 1, 1'b0, 8'h00), 1'b0, '0);
        add_row(mk(OP_PUT, 64, 1'b0, 8'hFF), 1'b0, '0);
        add_row(mk(OP_GET, 3, 1'b0, 8'h00), 1'b0, '0);
        add_row(mk(OP_PUT, 4, 1'b1, 8'h81), 1'b0, '0);
        add_row(mk(OP_PUT, 0, 1'b0, 8'h7E), 1'b0, '0);
        add_row(mk(OP_PUT, 1, 1'b1, 8'h42), 1'b0, '0);
        add_row(mk(OP_PUT, 0, 1'b0, 8'h99), 1'b0, '0);
        add_row(mk(OP_GET, 5, 1'b1, 8'hFF), 1'b0, '0);
        add_row(mk(OP_PUT, 64, 1'b1, 8'h01), 1'b0, '0);
        add_row(mk(OP_CLEAR, 0, 1'b0, 8'h00), 1'b1, brief(ST_OK, RING, 0));
        add_row(mk(OP_PUT, 0, 1'b0, 8'h55), 1'b1, brief(ST_NO_SPACE, RING, 0));
        add_row(mk(OP_GET, 64, 1'b0, 8'hAA), 1'b1, brief(ST_NO_DATA, RING, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        directed_words = words_sent;

        while (words_sent < directed_words + RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                len = pick_len();
                put_packet(len, (len > 0) ? len : 1);
            end
            else if (r < 72)
                get_packet(pick_get_len());
            else if (r < 80)
            begin
                len = $urandom_range(2, 20);
                put_packet(len, $urandom_range(1, len - 1));
            end
            else if (r < 86)
                put_byte($urandom_range(0, 127), 1'b0);
            else if (r < 90)
                put_packet($urandom_range(RING + 1, 127), $urandom_range(1, 3));
            else if (r < 93)
                send_word(mk(OP_CLEAR, $urandom_range(0, 127), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 255)), 1'b0, '0);
            else if (r < 97)
                send_word(mk(OP_NOP, $urandom_range(0, 127), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 255)), 1'b0, '0);
            else
                put_packet(0, 1);
        end
        start <= 1'b0;

        while (fifo_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d words (%0d from the table), checked %0d results, %0d bytes read back",
                 words_sent, directed_words, checked, read_bytes);
        $display("Mismatches: %0d", errors);
        if (errors == 0 && fifo_results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pbrf_pkg.sv
rtl/pbrf_ram.sv
rtl/pbrf_front.sv
rtl/pbrf_back.sv
rtl/packet_byte_ring_fifo.sv
tb/sv/packet_byte_ring_fifo_test.sv
